[hdl/tqur_pkg.sv]
// ----------------------------------------------------------------------------
// tqur_pkg
// Shared types and codes of the task queue with undo/redo history.
// ----------------------------------------------------------------------------
`default_nettype none

package tqur_pkg;

   // Configuration defaults
   localparam int PENDING_DEPTH_DEF = 16;
   localparam int HISTORY_DEPTH_DEF = 16;
   localparam int TASK_BITS_DEF     = 16;

   // Field widths of the stream ports
   localparam int CMD_W       = 2;
   localparam int TASK_ID_W   = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_USED_W  = STATUS_W + TASK_ID_W + 3 * COUNT_W;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DO   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNDO = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REDO = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic is_add;
      logic is_do;
      logic is_undo;
      logic is_redo;
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [TASK_ID_W-1:0]   task_id;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [TASK_ID_W-1:0] moved_id;
      logic [COUNT_W-1:0]   pending_count;
      logic [COUNT_W-1:0]   undo_count;
      logic [COUNT_W-1:0]   redo_count;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/task_queue_with_undo_redo.sv]
// ----------------------------------------------------------------------------
// task_queue_with_undo_redo
// Pending task FIFO with an undo/redo history kept in one shared store.
// ----------------------------------------------------------------------------
// Each request carries one command (add, do next, undo, redo) and produces
// exactly one response with a status, the task id that moved and the three
// fill counts after the command. In the back end a request first reads the
// pending and history memories through their registered read ports and then
// writes them and updates the counts; a new request is taken only after the
// last one has committed. A two-entry command queue in front and the response
// register at the back let the request side keep accepting while responses
// stall, until the queue is full. No clearing pass runs after reset; the block
// is ready as soon as reset is released.
`default_nettype none

module task_queue_with_undo_redo #(
   parameter int PENDING_DEPTH = tqur_pkg::PENDING_DEPTH_DEF,
   parameter int HISTORY_DEPTH = tqur_pkg::HISTORY_DEPTH_DEF,
   parameter int TASK_BITS     = tqur_pkg::TASK_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [1:0] cmd, [17:2] task_id, [23:18] zero
   input  wire  [tqur_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [1:0] status, [17:2] moved_id, [22:18] pending_count,
   // [27:23] undo_count, [32:28] redo_count, [39:33] zero
   output logic [tqur_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   logic              cmd_valid;
   logic              cmd_pop;
   tqur_pkg::cmd_type cmd;
   tqur_pkg::rsp_type rsp;

   tqur_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   tqur_back #(
      .PENDING_DEPTH (PENDING_DEPTH),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .TASK_BITS     (TASK_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {{tqur_pkg::RSP_PAD_W{1'b0}}, rsp.redo_count, rsp.undo_count,
                       rsp.pending_count, rsp.moved_id, rsp.status};

endmodule

`default_nettype wire

[hdl/tqur_front.sv]
// ----------------------------------------------------------------------------
// tqur_front
// Accepts requests, decodes the command into a kind and queues it for the
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tqur_front (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [1:0] cmd, [17:2] task_id, [23:18] zero
   input  wire  [tqur_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               cmd_valid,
   output tqur_pkg::cmd_type                  cmd,
   input  wire                                cmd_pop
);

   localparam int QD     = tqur_pkg::QUEUE_DEPTH;
   localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
   localparam int QCNT_W = $clog2(QD + 1);
   localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QD - 1);
   localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QD);

   tqur_pkg::cmd_type q_ff [QD];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   tqur_pkg::cmd_type decoded;
   logic push;

   always_comb begin
      decoded         = '0;
      decoded.task_id = req_tdata[tqur_pkg::CMD_W +: tqur_pkg::TASK_ID_W];
      unique case (req_tdata[tqur_pkg::CMD_W-1:0])
         tqur_pkg::CMD_ADD:  decoded.kind.is_add  = 1'b1;
         tqur_pkg::CMD_DO:   decoded.kind.is_do   = 1'b1;
         tqur_pkg::CMD_UNDO: decoded.kind.is_undo = 1'b1;
         tqur_pkg::CMD_REDO: decoded.kind.is_redo = 1'b1;
         default:            decoded.kind.is_add  = 1'b1;
      endcase
   end

   assign req_tready = (cnt_ff != QCNT_FULL);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != '0);
   assign cmd        = q_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_LAST) ? '0 : wptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rptr_in = (rptr_ff == QPTR_LAST) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

[hdl/tqur_back.sv]
// ----------------------------------------------------------------------------
// tqur_back
// Executes queued commands against the pending FIFO memory and the shared
// undo/redo history memory, and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tqur_back #(
   parameter int PENDING_DEPTH = tqur_pkg::PENDING_DEPTH_DEF,
   parameter int HISTORY_DEPTH = tqur_pkg::HISTORY_DEPTH_DEF,
   parameter int TASK_BITS     = tqur_pkg::TASK_BITS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cmd_valid,
   input  tqur_pkg::cmd_type   cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output tqur_pkg::rsp_type   rsp
);

   localparam int ID_W   = (TASK_BITS < tqur_pkg::TASK_ID_W) ? TASK_BITS
                                                             : tqur_pkg::TASK_ID_W;
   localparam int PIDX_W = $clog2(PENDING_DEPTH);
   localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int HIDX_W = $clog2(HISTORY_DEPTH);
   localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [PCNT_W-1:0] PD_CNT    = PCNT_W'(PENDING_DEPTH);
   localparam logic [PIDX_W:0]   PD_WRAP   = (PIDX_W + 1)'(PENDING_DEPTH);
   localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(PENDING_DEPTH - 1);
   localparam logic [HCNT_W-1:0] HD_CNT    = HCNT_W'(HISTORY_DEPTH);
   localparam logic [HCNT_W-1:0] HD_LAST   = HCNT_W'(HISTORY_DEPTH - 1);

   localparam logic [0:0] ST_ISSUE  = 1'b0;
   localparam logic [0:0] ST_COMMIT = 1'b1;

   logic [0:0]                      state_ff, state_in;
   logic [PIDX_W-1:0]               head_ff, head_in;
   logic [PCNT_W-1:0]               pfill_ff, pfill_in;
   logic [HCNT_W-1:0]               ufill_ff, ufill_in;
   logic [HCNT_W-1:0]               rfill_ff, rfill_in;
   tqur_pkg::kind_type              kind_ff;
   logic [tqur_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [ID_W-1:0]                 id_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   tqur_pkg::rsp_type               rsp_ff, rsp_in;

   logic [ID_W-1:0] pend_mem [PENDING_DEPTH];
   logic [ID_W-1:0] hist_mem [HISTORY_DEPTH];
   logic [ID_W-1:0] pend_rd_ff;
   logic [ID_W-1:0] hist_rd_ff;

   logic               take;
   logic               commit;
   logic               ok;
   logic [ID_W-1:0]    moved;
   logic [HCNT_W-1:0]  undo_top;
   logic [HCNT_W-1:0]  redo_top;
   logic [HCNT_W-1:0]  redo_push;
   logic [HIDX_W-1:0]  hist_raddr;
   logic [PIDX_W:0]    tail_sum;
   logic [PIDX_W-1:0]  pend_waddr;
   logic               pend_we;
   logic               hist_we;
   logic [HIDX_W-1:0]  hist_waddr;

   // A command is taken only when the result register will be free for it.
   assign take    = (state_ff == ST_ISSUE) && cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign commit  = (state_ff == ST_COMMIT);
   assign cmd_pop = take;

   // Undo grows up from entry 0, redo grows down from the last entry.
   assign undo_top   = ufill_ff - 1'b1;
   assign redo_top   = HD_CNT - rfill_ff;
   assign redo_push  = HD_LAST - rfill_ff;
   assign hist_raddr = cmd.kind.is_undo ? undo_top[HIDX_W-1:0] : redo_top[HIDX_W-1:0];

   always_comb begin
      status_in = tqur_pkg::ST_OK;
      priority if (cmd.kind.is_add) begin
         if (pfill_ff == PD_CNT) status_in = tqur_pkg::ST_FULL;
      end else if (cmd.kind.is_do) begin
         if (pfill_ff == '0) status_in = tqur_pkg::ST_EMPTY;
         else if (ufill_ff == HD_CNT) status_in = tqur_pkg::ST_FULL;
      end else if (cmd.kind.is_undo) begin
         if (ufill_ff == '0) status_in = tqur_pkg::ST_EMPTY;
      end else begin
         if (rfill_ff == '0) status_in = tqur_pkg::ST_EMPTY;
      end
   end

   // Commit state: read data is back, so write and update the fill counts.
   assign ok       = (status_ff == tqur_pkg::ST_OK);
   assign tail_sum = {1'b0, head_ff} + (PIDX_W + 1)'(pfill_ff);
   assign pend_waddr = (tail_sum >= PD_WRAP) ? PIDX_W'(tail_sum - PD_WRAP)
                                             : tail_sum[PIDX_W-1:0];
   assign pend_we    = commit && ok && kind_ff.is_add;
   assign hist_we    = commit && ok && !kind_ff.is_add;
   assign hist_waddr = kind_ff.is_undo ? redo_push[HIDX_W-1:0] : ufill_ff[HIDX_W-1:0];

   always_comb begin
      moved = '0;
      if (ok) begin
         if (kind_ff.is_add) moved = id_ff;
         else if (kind_ff.is_do) moved = pend_rd_ff;
         else moved = hist_rd_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      pfill_in     = pfill_ff;
      ufill_in     = ufill_ff;
      rfill_in     = rfill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_ISSUE: begin
            if (take) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_ISSUE;
            if (ok) begin
               priority if (kind_ff.is_add) begin
                  pfill_in = pfill_ff + 1'b1;
               end else if (kind_ff.is_do) begin
                  head_in  = (head_ff == PIDX_LAST) ? '0 : head_ff + 1'b1;
                  pfill_in = pfill_ff - 1'b1;
                  ufill_in = ufill_ff + 1'b1;
                  rfill_in = '0;
               end else if (kind_ff.is_undo) begin
                  ufill_in = ufill_ff - 1'b1;
                  rfill_in = rfill_ff + 1'b1;
               end else begin
                  ufill_in = ufill_ff + 1'b1;
                  rfill_in = rfill_ff - 1'b1;
               end
            end
            rsp_valid_in         = 1'b1;
            rsp_in.status        = status_ff;
            rsp_in.moved_id      = tqur_pkg::TASK_ID_W'(moved);
            rsp_in.pending_count = tqur_pkg::COUNT_W'(pfill_in);
            rsp_in.undo_count    = tqur_pkg::COUNT_W'(ufill_in);
            rsp_in.redo_count    = tqur_pkg::COUNT_W'(rfill_in);
         end
         default: state_in = ST_ISSUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE;
         head_ff      <= '0;
         pfill_ff     <= '0;
         ufill_ff     <= '0;
         rfill_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         pfill_ff     <= pfill_in;
         ufill_ff     <= ufill_in;
         rfill_ff     <= rfill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (take) begin
         kind_ff   <= cmd.kind;
         status_ff <= status_in;
         id_ff     <= cmd.task_id[ID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_waddr] <= id_ff;
      end
      pend_rd_ff <= pend_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= moved;
      end
      hist_rd_ff <= hist_mem[hist_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

[hdl/tqur_checker.sv]
// ----------------------------------------------------------------------------
// tqur_checker
// Port-level checks of the task queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tqur_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_tready,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [tqur_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   logic [tqur_pkg::STATUS_W-1:0]  rsp_status;
   logic [tqur_pkg::TASK_ID_W-1:0] rsp_moved;

   assign rsp_status = rsp_tdata[tqur_pkg::STATUS_W-1:0];
   assign rsp_moved  = rsp_tdata[tqur_pkg::STATUS_W +: tqur_pkg::TASK_ID_W];

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A refused or empty command never reports a moved id.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != tqur_pkg::ST_OK) |-> rsp_moved == '0)
      else $error("moved id set on a command that did nothing");

   // Only the three defined status codes appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == tqur_pkg::ST_OK) || (rsp_status == tqur_pkg::ST_EMPTY)
                     || (rsp_status == tqur_pkg::ST_FULL))
      else $error("undefined status code");

   // Reset leaves no response pending and the request side free.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state left over after reset");

   // Responses need a request; none rises right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(reset) && !$past(reset, 2))
      else $error("response without a request");

endmodule

bind task_queue_with_undo_redo tqur_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
